/* hdl/tcbpa_pkg.sv */
// Shared types and constants for the two-class block pool allocator.
// Used by the pool module and the top level; no dependencies.
package tcbpa_pkg;

   localparam int SIZE_W = 16;
   localparam int HANDLE_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [SIZE_W-1:0] SMALL_MAX_RESET = 16'd15;
   localparam logic [SIZE_W-1:0] LARGE_MAX_RESET = 16'd180;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_UNSUPPORTED = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMALL_MAX = 1'b0,
      CSR_LARGE_MAX = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic pop;
      logic push;
      logic [HANDLE_W-1:0] index;
   } pool_cmd_type;

endpackage

/* hdl/tcbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tcbpa_pool.sv */
// One LIFO free list: head, cached successor of the head and next-pointer RAM.
// Depends on tcbpa_pkg and tcbpa_ram.
module tcbpa_pool #(
   parameter int BLOCKS = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tcbpa_pkg::pool_cmd_type   cmd,
   output logic [$clog2(BLOCKS+1)-1:0] head,
   output logic                      empty
);
   import tcbpa_pkg::*;

   localparam int IDX_W = $clog2(BLOCKS + 1);
   localparam int ADDR_W = $clog2(BLOCKS);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] nxt_ff, nxt_in;
   logic             pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_dflt_ff, pend_dflt_in;
   logic [BLOCKS-1:0] valid_ff, valid_in;

   logic [IDX_W-1:0]  nxt_cur;
   logic [IDX_W-1:0]  push_idx;
   logic [IDX_W-1:0]  nxt_minus;
   logic [IDX_W-1:0]  push_minus;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [IDX_W-1:0]  rd_data;
   logic              rd_en;
   logic              wr_en;

   tcbpa_ram #(
      .WIDTH(IDX_W),
      .DEPTH(BLOCKS)
   ) u_next_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(head_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      nxt_cur = pend_ff ? (pend_valid_ff ? rd_data : pend_dflt_ff) : nxt_ff;
      push_idx = cmd.index[IDX_W-1:0];
      nxt_minus = nxt_cur - 1'b1;
      push_minus = push_idx - 1'b1;
      rd_addr = nxt_minus[ADDR_W-1:0];
      wr_addr = push_minus[ADDR_W-1:0];
      rd_en = cmd.pop && (nxt_cur != '0);
      wr_en = cmd.push;

      head_in = head_ff;
      nxt_in = nxt_cur;
      pend_in = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_dflt_in = pend_dflt_ff;
      valid_in = valid_ff;

      if (cmd.pop) begin
         head_in = nxt_cur;
         if (nxt_cur != '0) begin
            pend_in = 1'b1;
            pend_valid_in = valid_ff[rd_addr];
            pend_dflt_in = (nxt_cur < IDX_W'(BLOCKS)) ? nxt_cur + 1'b1 : '0;
         end else begin
            nxt_in = '0;
         end
      end else if (cmd.push) begin
         head_in = push_idx;
         nxt_in = head_ff;
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= IDX_W'(1);
         nxt_ff <= IDX_W'(2);
         pend_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         head_ff <= head_in;
         nxt_ff <= nxt_in;
         pend_ff <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_valid_ff <= pend_valid_in;
      pend_dflt_ff <= pend_dflt_in;
   end

   assign head = head_ff;
   assign empty = (head_ff == '0);

endmodule

/* hdl/two_class_block_pool_allocator.sv */
// Top level of the two-class block pool allocator: request register, decode and result register.
// Depends on tcbpa_pkg and tcbpa_pool.

// A request is taken in every cycle in which start is high; busy never rises. Each request gives
// exactly one result, shown on the rsp_ ports with rsp_valid high for one cycle, after passing the
// request and result registers, a pool list being updated with the result. Each pool keeps its
// head and the head's successor in registers and refills the successor from its next-pointer RAM
// in the cycle after a pop, so back-to-back requests run at one per cycle. Entries not yet written
// since reset read as the initial in-order link, so the block is ready right after reset.
module two_class_block_pool_allocator #(
   parameter int SMALL_BLOCKS = 128,
   parameter int LARGE_BLOCKS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic [tcbpa_pkg::SIZE_W-1:0]         req_request_size,
   input  logic [tcbpa_pkg::HANDLE_W-1:0]       req_free_handle,
   output logic                                 rsp_valid,
   output logic [tcbpa_pkg::HANDLE_W-1:0]       rsp_grant_handle,
   output logic [1:0]                           rsp_status,
   input  logic                                 csr_write_enable,
   input  logic [tcbpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcbpa_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import tcbpa_pkg::*;

   localparam int SIDX_W = $clog2(SMALL_BLOCKS + 1);
   localparam int LIDX_W = $clog2(LARGE_BLOCKS + 1);

   logic [SIZE_W-1:0]   small_max_ff;
   logic [SIZE_W-1:0]   large_max_ff;
   logic                req_valid_ff;
   opcode_type          opcode_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                rsp_valid_ff;
   logic [HANDLE_W-1:0] grant_ff, grant_in;
   status_type          status_ff, status_in;

   pool_cmd_type      small_cmd, large_cmd;
   logic [SIDX_W-1:0] small_head;
   logic [LIDX_W-1:0] large_head;
   logic              small_empty, large_empty;

   tcbpa_pool #(.BLOCKS(SMALL_BLOCKS)) u_small_pool (
      .clock(clock),
      .reset(reset),
      .cmd  (small_cmd),
      .head (small_head),
      .empty(small_empty)
   );

   tcbpa_pool #(.BLOCKS(LARGE_BLOCKS)) u_large_pool (
      .clock(clock),
      .reset(reset),
      .cmd  (large_cmd),
      .head (large_head),
      .empty(large_empty)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         small_max_ff <= SMALL_MAX_RESET;
         large_max_ff <= LARGE_MAX_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SMALL_MAX: small_max_ff <= csr_write_data;
            CSR_LARGE_MAX: large_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_type'(req_opcode);
      size_ff <= req_request_size;
      handle_ff <= req_free_handle;
      grant_ff <= grant_in;
      status_ff <= status_in;
   end

   always_comb begin
      small_cmd = '0;
      large_cmd = '0;
      grant_in = '0;
      status_in = STATUS_OK;
      if (opcode_ff == OP_ALLOC) begin
         if ((size_ff != '0) && (size_ff <= small_max_ff)) begin
            if (small_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               grant_in = HANDLE_W'(small_head);
               small_cmd.pop = req_valid_ff;
            end
         end else if ((size_ff > small_max_ff) && (size_ff <= large_max_ff)) begin
            if (large_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               grant_in = HANDLE_W'(SMALL_BLOCKS) + HANDLE_W'(large_head);
               large_cmd.pop = req_valid_ff;
            end
         end else begin
            status_in = STATUS_UNSUPPORTED;
         end
      end else begin
         if ((handle_ff != '0) && (handle_ff <= HANDLE_W'(SMALL_BLOCKS))) begin
            small_cmd.push = req_valid_ff;
            small_cmd.index = handle_ff;
         end else if ((handle_ff > HANDLE_W'(SMALL_BLOCKS)) &&
                      (handle_ff <= HANDLE_W'(SMALL_BLOCKS + LARGE_BLOCKS))) begin
            large_cmd.push = req_valid_ff;
            large_cmd.index = handle_ff - HANDLE_W'(SMALL_BLOCKS);
         end else begin
            status_in = STATUS_IGNORED;
         end
      end
   end

   assign busy = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_grant_handle = grant_ff;
   assign rsp_status = status_ff;

`ifndef ASSERT_OFF
   a_result_follows_request: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_valid)
      else $error("accepted request produced no result");

   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without a request");

   a_grant_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_grant_handle == '0))
      else $error("handle granted with a failure status");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(small_cmd.pop && small_empty) && !(large_cmd.pop && large_empty))
      else $error("pop from an empty pool");

   a_single_pool_op: assert property (@(posedge clock) disable iff (reset)
      $countones({small_cmd.pop, small_cmd.push, large_cmd.pop, large_cmd.push}) <= 1)
      else $error("more than one pool updated by one request");
`endif

endmodule
